### sv/multi_queue_message_fifo_unit_assert.svh
// Assertion macros used by the message queue datapath.
`ifndef MULTI_QUEUE_MESSAGE_FIFO_UNIT_ASSERT_SVH
`define MULTI_QUEUE_MESSAGE_FIFO_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MQMF_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MQMF_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`else

`define MQMF_ASSERT_IMPL(label, ck, rs, ante, cons, msg)
`define MQMF_ASSERT_NEXT(label, ck, rs, ante, cons, msg)

`endif

`endif

### sv/mqmf_pkg.sv
// Types, codes and defaults of the multi-queue message FIFO.
package mqmf_pkg;

  localparam int QUEUES_DEF     = 4;
  localparam int QUEUE_SIZE_DEF = 256;

  // wide enough for length + 1 and for any free count
  localparam int CNT_W = 10;

  localparam logic [2:0] FN_CLEAR    = 3'd0;
  localparam logic [2:0] FN_PUT_HDR  = 3'd1;
  localparam logic [2:0] FN_PUT_BYTE = 3'd2;
  localparam logic [2:0] FN_GET_HDR  = 3'd3;
  localparam logic [2:0] FN_GET_BYTE = 3'd4;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_BAD_QUEUE = 3'd1;
  localparam logic [2:0] STS_NO_DATA   = 3'd2;
  localparam logic [2:0] STS_NO_ROOM   = 3'd3;
  localparam logic [2:0] STS_EMPTY     = 3'd4;
  localparam logic [2:0] STS_SMALL     = 3'd5;
  localparam logic [2:0] STS_NO_OPEN   = 3'd6;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] queue;
    logic [7:0] length;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] msg_length;
    logic [7:0] byte_out;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic accept;  // request beat taken this cycle
    logic exec;    // latched item is being worked on
    logic commit;  // result and state updates land this cycle
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### sv/mqmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mqmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/mqmf_ctrl.sv
// Two-state sequencer: take a beat, then commit it once the result slot is free.
module mqmf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  mqmf_pkg::dp_stat_t  stat,
  output mqmf_pkg::ctl_cmd_t  cmd,
  output logic                req_stall
);
  import mqmf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = req_valid;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        cmd.commit = stat.out_free;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/mqmf_datapath.sv
// Queue pointers, open-transfer registers, byte store and result register.
`include "multi_queue_message_fifo_unit_assert.svh"

module mqmf_datapath #(
  parameter int QUEUES     = mqmf_pkg::QUEUES_DEF,
  parameter int QUEUE_SIZE = mqmf_pkg::QUEUE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mqmf_pkg::ctl_cmd_t  cmd,
  output mqmf_pkg::dp_stat_t  stat,
  input  mqmf_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mqmf_pkg::rsp_t      rsp
);
  import mqmf_pkg::*;

  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_SIZE);
  localparam int FW    = $clog2(QUEUE_SIZE + 1);
  localparam int AW    = QW + PW;
  localparam int DEPTH = 1 << AW;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_SIZE - 1)) ? '0 : p + PW'(1);
  endfunction

  // per-queue state
  logic [PW-1:0] head_ptr   [QUEUES];
  logic [PW-1:0] tail_ptr   [QUEUES];
  logic [FW-1:0] free_count [QUEUES];

  // open transfers
  logic          put_open, put_open_next;
  logic [QW-1:0] put_target, put_target_next;
  logic [7:0]    put_remaining, put_remaining_next;
  logic [7:0]    put_len, put_len_next;
  logic [PW-1:0] put_wp, put_wp_next;
  logic          get_open, get_open_next;
  logic [QW-1:0] get_target, get_target_next;
  logic [7:0]    get_remaining, get_remaining_next;
  logic [7:0]    get_len, get_len_next;
  logic [PW-1:0] get_rp, get_rp_next;

  req_t          lat;
  rsp_t          res;

  logic [QW-1:0] aq_in, aq_lat, sel_q;
  logic [PW-1:0] head_sel, tail_sel;
  logic [FW-1:0] free_sel;
  logic          qok;

  logic          head_we, tail_we, free_we;
  logic [PW-1:0] head_w, tail_w;
  logic [FW-1:0] free_w;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [CNT_W-1:0] need, sum;

  // queue an item works on: the open transfer's for byte items
  always_comb begin
    case (req.func)
      FN_PUT_BYTE: aq_in = put_target;
      FN_GET_BYTE: aq_in = get_target;
      default:     aq_in = req.queue[QW-1:0];
    endcase
    case (lat.func)
      FN_PUT_BYTE: aq_lat = put_target;
      FN_GET_BYTE: aq_lat = get_target;
      default:     aq_lat = lat.queue[QW-1:0];
    endcase
  end

  // one read index into the pointer arrays per cycle
  assign sel_q    = cmd.exec ? aq_lat : aq_in;
  assign head_sel = head_ptr[sel_q];
  assign tail_sel = tail_ptr[sel_q];
  assign free_sel = free_count[sel_q];
  assign qok      = ({1'b0, lat.queue} < 4'(QUEUES));

  // store read goes out with the accepted beat
  assign ram_re    = cmd.accept && (req.func == FN_GET_HDR || req.func == FN_GET_BYTE);
  assign ram_raddr = (req.func == FN_GET_BYTE) ? {get_target, get_rp} : {aq_in, head_sel};

  always_comb begin
    res                = '{status: STS_NO_OPEN, msg_length: 8'd0, byte_out: 8'd0, last: 1'b0};
    put_open_next      = put_open;
    put_target_next    = put_target;
    put_remaining_next = put_remaining;
    put_len_next       = put_len;
    put_wp_next        = put_wp;
    get_open_next      = get_open;
    get_target_next    = get_target;
    get_remaining_next = get_remaining;
    get_len_next       = get_len;
    get_rp_next        = get_rp;
    head_we            = 1'b0;
    tail_we            = 1'b0;
    free_we            = 1'b0;
    head_w             = head_sel;
    tail_w             = tail_sel;
    free_w             = free_sel;
    ram_we             = 1'b0;
    ram_waddr          = {aq_lat, tail_sel};
    ram_wdata          = lat.length;
    need               = {2'b00, lat.length} + CNT_W'(1);
    sum                = CNT_W'(free_sel) + CNT_W'(get_len) + CNT_W'(1);

    unique case (lat.func)
      FN_CLEAR: begin
        if (!qok) begin
          res.status = STS_BAD_QUEUE;
        end else begin
          head_we = 1'b1;
          tail_we = 1'b1;
          free_we = 1'b1;
          head_w  = '0;
          tail_w  = '0;
          free_w  = FW'(QUEUE_SIZE);
          if (put_open && put_target == aq_lat) put_open_next = 1'b0;
          if (get_open && get_target == aq_lat) get_open_next = 1'b0;
          res.status = STS_OK;
        end
      end
      FN_PUT_HDR: begin
        put_open_next = 1'b0;
        if (!qok) begin
          res.status = STS_BAD_QUEUE;
        end else if (lat.length == 8'd0) begin
          res.status = STS_NO_DATA;
        end else if (need > CNT_W'(free_sel)) begin
          res.status = STS_NO_ROOM;
        end else begin
          ram_we             = 1'b1;
          put_open_next      = 1'b1;
          put_target_next    = aq_lat;
          put_remaining_next = lat.length;
          put_len_next       = lat.length;
          put_wp_next        = ptr_inc(tail_sel);
          res.status         = STS_OK;
        end
      end
      FN_PUT_BYTE: begin
        if (put_open) begin
          ram_we             = 1'b1;
          ram_waddr          = {put_target, put_wp};
          ram_wdata          = lat.data;
          put_wp_next        = ptr_inc(put_wp);
          put_remaining_next = put_remaining - 8'd1;
          if (put_remaining == 8'd1) begin
            // message complete: publish it
            tail_we       = 1'b1;
            free_we       = 1'b1;
            tail_w        = ptr_inc(put_wp);
            free_w        = free_sel - FW'(put_len) - FW'(1);
            put_open_next = 1'b0;
          end
          res.status = STS_OK;
        end
      end
      FN_GET_HDR: begin
        get_open_next = 1'b0;
        if (!qok) begin
          res.status = STS_BAD_QUEUE;
        end else if (free_sel >= FW'(QUEUE_SIZE)) begin
          res.status = STS_EMPTY;
        end else begin
          res.msg_length = ram_rdata;
          if (ram_rdata > lat.length) begin
            res.status = STS_SMALL;
          end else begin
            if (ram_rdata == 8'd0) begin
              // zero-length entry: drop the length byte
              head_we = 1'b1;
              free_we = 1'b1;
              head_w  = ptr_inc(head_sel);
              free_w  = free_sel + FW'(1);
            end else begin
              get_open_next      = 1'b1;
              get_target_next    = aq_lat;
              get_remaining_next = ram_rdata;
              get_len_next       = ram_rdata;
              get_rp_next        = ptr_inc(head_sel);
            end
            res.status = STS_OK;
          end
        end
      end
      FN_GET_BYTE: begin
        if (get_open) begin
          res.byte_out       = ram_rdata;
          get_rp_next        = ptr_inc(get_rp);
          get_remaining_next = get_remaining - 8'd1;
          if (get_remaining == 8'd1) begin
            head_we       = 1'b1;
            free_we       = 1'b1;
            head_w        = ptr_inc(get_rp);
            free_w        = (sum > CNT_W'(QUEUE_SIZE)) ? FW'(QUEUE_SIZE) : sum[FW-1:0];
            get_open_next = 1'b0;
            res.last      = 1'b1;
          end
          res.status = STS_OK;
        end
      end
      default: res.status = STS_NO_OPEN;
    endcase
  end

  mqmf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we && cmd.commit),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat <= req;
    end
    if (cmd.commit) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_ptr[i]   <= '0;
        tail_ptr[i]   <= '0;
        free_count[i] <= FW'(QUEUE_SIZE);
      end
      put_open      <= 1'b0;
      put_target    <= '0;
      put_remaining <= '0;
      put_len       <= '0;
      put_wp        <= '0;
      get_open      <= 1'b0;
      get_target    <= '0;
      get_remaining <= '0;
      get_len       <= '0;
      get_rp        <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (head_we) head_ptr[aq_lat]   <= head_w;
        if (tail_we) tail_ptr[aq_lat]   <= tail_w;
        if (free_we) free_count[aq_lat] <= free_w;
        put_open      <= put_open_next;
        put_target    <= put_target_next;
        put_remaining <= put_remaining_next;
        put_len       <= put_len_next;
        put_wp        <= put_wp_next;
        get_open      <= get_open_next;
        get_target    <= get_target_next;
        get_remaining <= get_remaining_next;
        get_len       <= get_len_next;
        get_rp        <= get_rp_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `MQMF_ASSERT_NEXT(a_commit_loads_rsp, clk, rst, cmd.commit, rsp_valid, "commit without result beat")
  `MQMF_ASSERT_IMPL(a_put_open_rem, clk, rst, put_open, put_remaining != 8'd0, "open put with nothing left")
  `MQMF_ASSERT_NEXT(a_get_last_closes, clk, rst, cmd.commit && lat.func == FN_GET_BYTE && get_open && get_remaining == 8'd1, !get_open && rsp.last, "final get byte did not close the get")

endmodule

### sv/multi_queue_message_fifo_unit.sv
// Top level of the multi-queue message FIFO: sequencer plus datapath.
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_stall  | func, queue, length, data
//   rsp     | out | rsp_valid/rsp_stall  | status, msg_length, byte_out, last
//
// The accept cycle issues the byte store read; the work state that follows
// uses the registered read data and loads the result register. A new request
// is taken the cycle after the result is loaded, so no request is taken while
// one is in work; the store's registered read port is why the work state is
// needed. A stalled result holds the block in its work cycle until the slot
// frees. Reset empties every queue; the store needs no clearing pass.
module multi_queue_message_fifo_unit #(
  parameter int QUEUES     = mqmf_pkg::QUEUES_DEF,
  parameter int QUEUE_SIZE = mqmf_pkg::QUEUE_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mqmf_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mqmf_pkg::rsp_t  rsp
);
  import mqmf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mqmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  mqmf_datapath #(
    .QUEUES     (QUEUES),
    .QUEUE_SIZE (QUEUE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### bench/tb_multi_queue_message_fifo_unit.sv
// Self-checking bench for the multi-queue message FIFO: shadow queues, random traffic.
`timescale 1ns / 100ps

module tb_multi_queue_message_fifo_unit;
  import mqmf_pkg::*;

  localparam int QUEUES     = QUEUES_DEF;
  localparam int QUEUE_SIZE = QUEUE_SIZE_DEF;
  localparam int RAND_ITEMS = 1250;

  // Shadow copy of the queues; predicts one response per request beat.
  class queue_mirror;
    logic [7:0]  mem [QUEUES][QUEUE_SIZE];
    int unsigned head [QUEUES];
    int unsigned tail [QUEUES];
    int unsigned room [QUEUES];
    bit          put_on, get_on;
    int unsigned put_q, put_left, get_q, get_left;
    rsp_t        exp_rsp [$];
    int          errors, results;
    int          sts_seen [8];

    function new();
      for (int q = 0; q < QUEUES; q++) begin
        head[q] = 0;
        tail[q] = 0;
        room[q] = QUEUE_SIZE;
      end
      put_on  = 0;
      get_on  = 0;
      errors  = 0;
      results = 0;
    endfunction

    function rsp_t take_request(req_t r);
      rsp_t        e;
      int unsigned q, stored, pos;
      bit          qok;
      e = '0;
      e.status = STS_NO_OPEN;
      q = r.queue;
      qok = (q < QUEUES);
      case (r.func)
        FN_CLEAR: begin
          if (!qok) begin
            e.status = STS_BAD_QUEUE;
          end else begin
            head[q] = 0;
            tail[q] = 0;
            room[q] = QUEUE_SIZE;
            if (put_on && put_q == q) put_on = 0;
            if (get_on && get_q == q) get_on = 0;
            e.status = STS_OK;
          end
        end
        FN_PUT_HDR: begin
          put_on = 0;
          if (!qok) e.status = STS_BAD_QUEUE;
          else if (r.length == 0) e.status = STS_NO_DATA;
          else if (r.length + 1 > room[q]) e.status = STS_NO_ROOM;
          else begin
            mem[q][tail[q]] = r.length;
            put_on   = 1;
            put_q    = q;
            put_left = r.length;
            e.status = STS_OK;
          end
        end
        FN_PUT_BYTE: begin
          if (put_on) begin
            stored = mem[put_q][tail[put_q]];
            pos = (tail[put_q] + 1 + stored - put_left) % QUEUE_SIZE;
            mem[put_q][pos] = r.data;
            put_left--;
            // message becomes visible only with its final byte
            if (put_left == 0) begin
              tail[put_q] = (tail[put_q] + stored + 1) % QUEUE_SIZE;
              room[put_q] = (room[put_q] >= stored + 1) ? room[put_q] - stored - 1 : 0;
              put_on = 0;
            end
            e.status = STS_OK;
          end
        end
        FN_GET_HDR: begin
          get_on = 0;
          if (!qok) e.status = STS_BAD_QUEUE;
          else if (room[q] >= QUEUE_SIZE) e.status = STS_EMPTY;
          else begin
            stored = mem[q][head[q]];
            e.msg_length = stored;
            if (stored > r.length) begin
              e.status = STS_SMALL;
            end else begin
              e.status = STS_OK;
              if (stored == 0) begin
                head[q] = (head[q] + 1) % QUEUE_SIZE;
                room[q] = (room[q] + 1 > QUEUE_SIZE) ? QUEUE_SIZE : room[q] + 1;
              end else begin
                get_on   = 1;
                get_q    = q;
                get_left = stored;
              end
            end
          end
        end
        FN_GET_BYTE: begin
          if (get_on) begin
            stored = mem[get_q][head[get_q]];
            pos = (head[get_q] + 1 + stored - get_left) % QUEUE_SIZE;
            e.byte_out = mem[get_q][pos];
            get_left--;
            if (get_left == 0) begin
              head[get_q] = (head[get_q] + stored + 1) % QUEUE_SIZE;
              room[get_q] = room[get_q] + stored + 1;
              if (room[get_q] > QUEUE_SIZE) room[get_q] = QUEUE_SIZE;
              get_on = 0;
              e.last = 1'b1;
            end
            e.status = STS_OK;
          end
        end
        default: ;
      endcase
      exp_rsp.push_back(e);
      sts_seen[e.status]++;
      return e;
    endfunction

    function void compare_response(rsp_t a);
      rsp_t e;
      results++;
      if (exp_rsp.size() == 0) begin
        errors++;
        $display("%0t: response beat with nothing pending: %p", $time, a);
        return;
      end
      e = exp_rsp.pop_front();
      if (a.status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, e.status, a.status);
      end
      if (a.msg_length !== e.msg_length) begin
        errors++;
        $display("%0t: msg_length expected %0d got %0d", $time, e.msg_length, a.msg_length);
      end
      if (a.byte_out !== e.byte_out) begin
        errors++;
        $display("%0t: byte_out expected 0x%02h got 0x%02h", $time, e.byte_out, a.byte_out);
      end
      if (a.last !== e.last) begin
        errors++;
        $display("%0t: last expected %0b got %0b", $time, e.last, a.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_beat = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_beat;

  bit          steady = 0;
  int          useful_items = 0;
  int          sent_items = 0;
  queue_mirror mirror = new();

  multi_queue_message_fifo_unit #(
    .QUEUES     (QUEUES),
    .QUEUE_SIZE (QUEUE_SIZE)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_beat)
  );

  always #10 clk = ~clk;

  // response side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) mirror.compare_response(rsp_beat);
    rsp_stall <= !steady && ($urandom_range(0, 99) < 9);
  end

  function automatic req_t mk(logic [2:0] f, logic [2:0] q, logic [7:0] len, logic [7:0] d);
    req_t r;
    r.func   = f;
    r.queue  = q;
    r.length = len;
    r.data   = d;
    return r;
  endfunction

  // mostly valid queue numbers, now and then an out-of-range one
  function automatic logic [2:0] pick_queue();
    if ($urandom_range(0, 99) < 95) return $urandom_range(0, QUEUES - 1);
    return $urandom_range(QUEUES, 7);
  endfunction

  task automatic send(input req_t r, output rsp_t e);
    while (!steady && $urandom_range(0, 99) < 9) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_beat  <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    e = mirror.take_request(r);
    sent_items++;
    if (e.status != STS_NO_OPEN) useful_items++;
  endtask

  task automatic put_message(input logic [2:0] q, input logic [7:0] len);
    rsp_t e;
    int   stop_at;
    send(mk(FN_PUT_HDR, q, len, $urandom_range(0, 255)), e);
    if (e.status != STS_OK) return;
    // occasionally abandon the transfer part way
    stop_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < stop_at; i++) send(mk(FN_PUT_BYTE, 0, 0, $urandom_range(0, 255)), e);
  endtask

  task automatic get_message(input logic [2:0] q, input logic [7:0] cap);
    rsp_t e;
    int   stop_at;
    send(mk(FN_GET_HDR, q, cap, $urandom_range(0, 255)), e);
    if (e.status != STS_OK) return;
    stop_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, e.msg_length) : e.msg_length;
    for (int i = 0; i < stop_at; i++) send(mk(FN_GET_BYTE, 0, 0, $urandom_range(0, 255)), e);
  endtask

  initial begin
    rsp_t e;
    int   pick, len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send(mk(FN_GET_HDR, 0, 8'hFF, 8'h00), e);      // empty queue
    send(mk(FN_PUT_BYTE, 0, 8'h00, 8'hFF), e);     // byte with no open put
    send(mk(FN_GET_BYTE, 0, 8'hFF, 8'h00), e);     // byte with no open get
    send(mk(3'd5, 3'd7, 8'hFF, 8'hFF), e);         // unused function codes
    send(mk(3'd6, 3'd0, 8'h00, 8'h00), e);
    send(mk(3'd7, 3'd7, 8'hFF, 8'hFF), e);
    send(mk(FN_CLEAR, 3'd7, 8'h00, 8'h00), e);     // bad queue numbers
    send(mk(FN_PUT_HDR, QUEUES, 8'h05, 8'h00), e);
    send(mk(FN_GET_HDR, 3'd5, 8'hFF, 8'h00), e);
    send(mk(FN_PUT_HDR, 3'd1, 8'h00, 8'h00), e);   // zero length
    send(mk(FN_PUT_HDR, 3'd1, 8'h02, 8'h00), e);
    send(mk(FN_PUT_BYTE, 0, 8'h00, 8'h00), e);
    send(mk(FN_PUT_BYTE, 0, 8'h00, 8'hFF), e);
    send(mk(FN_GET_HDR, 3'd1, 8'h01, 8'h00), e);   // capacity too small
    send(mk(FN_GET_HDR, 3'd1, 8'hFF, 8'h00), e);
    send(mk(FN_GET_BYTE, 0, 8'h00, 8'h00), e);
    send(mk(FN_GET_BYTE, 0, 8'h00, 8'h00), e);
    send(mk(FN_PUT_HDR, 3'd3, 8'h03, 8'h00), e);   // abandoned by a new header
    send(mk(FN_PUT_BYTE, 0, 8'h00, 8'hA5), e);
    send(mk(FN_PUT_HDR, 3'd3, 8'h01, 8'h00), e);
    send(mk(FN_PUT_BYTE, 0, 8'h00, 8'h5A), e);
    send(mk(FN_GET_HDR, 3'd3, 8'h01, 8'h00), e);   // clear drops an open get
    send(mk(FN_CLEAR, 3'd3, 8'h00, 8'h00), e);
    send(mk(FN_GET_BYTE, 0, 8'h00, 8'h00), e);
    send(mk(FN_GET_HDR, 3'd3, 8'hFF, 8'h00), e);

    // random traffic, mostly well-formed transfers
    while (useful_items < RAND_ITEMS + 25) begin
      steady = (useful_items > 450 && useful_items < 750);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send(mk($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 255),
                $urandom_range(0, 255)), e);
      end else if (pick < 10) begin
        send(mk(FN_CLEAR, pick_queue(), $urandom_range(0, 255), $urandom_range(0, 255)), e);
      end else if (pick < 60) begin
        len = $urandom_range(0, 99);
        if (len < 4) len = 0;
        else if (len < 10) len = $urandom_range(60, 255);
        else len = $urandom_range(1, 12);
        put_message(pick_queue(), len);
      end else begin
        get_message(pick_queue(), ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 255);
      end
    end
    steady = 0;
    req_valid <= 1'b0;

    while (mirror.exp_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run sent %0d request beats (%0d doing work) and checked %0d responses on %0d queues.",
             sent_items, useful_items, mirror.results, QUEUES);
    $display("Status mix: ok %0d, bad queue %0d, no data %0d, no room %0d, empty %0d, small %0d, no open %0d",
             mirror.sts_seen[STS_OK], mirror.sts_seen[STS_BAD_QUEUE],
             mirror.sts_seen[STS_NO_DATA], mirror.sts_seen[STS_NO_ROOM],
             mirror.sts_seen[STS_EMPTY], mirror.sts_seen[STS_SMALL],
             mirror.sts_seen[STS_NO_OPEN]);
    if (mirror.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d responses outstanding", $time, mirror.exp_rsp.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/mqmf_pkg.sv
sv/mqmf_ram.sv
sv/mqmf_ctrl.sv
sv/mqmf_datapath.sv
sv/multi_queue_message_fifo_unit.sv
bench/tb_multi_queue_message_fifo_unit.sv
